>>> src/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int MAX_PAYLOAD = 252;

	localparam logic [7:0] START_BYTE = 8'd253;
	localparam logic [7:0] END_BYTE   = 8'd254;
	localparam logic [7:0] BAD_BYTE   = 8'd255;
	localparam logic [8:0] HUNT_LIMIT = 9'd253;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
	localparam logic [2:0] ST_INVALID    = 3'd2;
	localparam logic [2:0] ST_CRC        = 3'd3;
	localparam logic [2:0] ST_NO_START   = 3'd4;
	localparam logic [2:0] ST_ABORTED    = 3'd5;

	localparam logic [1:0] ADDR_USE_CRC = 2'd0;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_COLLECT = 4'b0010,
		PH_CRC_LO  = 4'b0100,
		PH_CRC_HI  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       frame_end;
		logic [2:0] frame_status;
		logic [7:0] payload_count;
	} result_t;

	// crc-16/kermit, one byte, reflected form
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		logic [7:0]  a;
		begin
			x = crc ^ {8'h00, b};
			a = x[7:0] ^ {x[3:0], 4'b0000};
			crc_update = {8'h00, x[15:8]} ^ {a, 8'h00} ^ {5'b00000, a, 3'b000}
				^ {12'h000, a[7:4]};
		end
	endfunction

	localparam logic [15:0] CRC_START = crc_update(16'h0000, START_BYTE);

	function automatic logic [2:0] frame_verdict(
		input logic        bad_seen,
		input logic        held_valid,
		input logic [7:0]  held_byte,
		input logic [8:0]  byte_count,
		input logic        check_crc,
		input logic [15:0] rx_crc,
		input logic [15:0] run_crc
	);
		begin
			if (bad_seen)
				frame_verdict = ST_INVALID;
			else if (held_valid && held_byte == BAD_BYTE
					&& byte_count <= 9'(MAX_PAYLOAD + 2))
				frame_verdict = ST_INVALID;
			else if (!held_valid || {1'b0, held_byte} != byte_count - 9'd2
					|| held_byte < 8'd4)
				frame_verdict = ST_BAD_LENGTH;
			else if (check_crc && rx_crc != run_crc)
				frame_verdict = ST_CRC;
			else
				frame_verdict = ST_OK;
		end
	endfunction

endpackage

>>> src/sfd_frame.sv
`timescale 1ns / 1ps

module sfd_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           byte_in,
	input  logic                 use_crc,
	output logic                 res_vld,
	output sfd_pkg::result_t     res
);

	sfd_pkg::phase_t phase_q, phase_d;
	logic [8:0]  byte_count_q, byte_count_d;
	logic [7:0]  held_byte_q, held_byte_d;
	logic        held_valid_q, held_valid_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;
	logic        bad_seen_q, bad_seen_d;
	logic [7:0]  emitted_q, emitted_d;
	logic [8:0]  bc_inc;

	assign bc_inc = byte_count_q + 9'd1;

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		crc_d        = crc_q;
		crc_low_d    = crc_low_q;
		bad_seen_d   = bad_seen_q;
		emitted_d    = emitted_q;
		res_vld      = 1'b0;
		res          = '0;
		res.frame_end = 1'b1;
		res.payload_count = emitted_q;
		if (byte_in == sfd_pkg::START_BYTE) begin
			// a start byte always opens a new frame, aborting any open one
			phase_d      = sfd_pkg::PH_COLLECT;
			byte_count_d = 9'd1;
			held_byte_d  = 8'd0;
			held_valid_d = 1'b0;
			bad_seen_d   = 1'b0;
			emitted_d    = 8'd0;
			crc_d        = sfd_pkg::CRC_START;
			crc_low_d    = 8'd0;
			res_vld      = (phase_q != sfd_pkg::PH_HUNT);
			res.frame_status = sfd_pkg::ST_ABORTED;
		end else begin
			unique case (phase_q)
				sfd_pkg::PH_HUNT: begin
					byte_count_d = bc_inc;
					if (bc_inc > sfd_pkg::HUNT_LIMIT) begin
						byte_count_d      = 9'd0;
						res_vld           = 1'b1;
						res.frame_status  = sfd_pkg::ST_NO_START;
						res.payload_count = 8'd0;
					end
				end
				sfd_pkg::PH_COLLECT: begin
					byte_count_d = bc_inc;
					crc_d = sfd_pkg::crc_update(crc_q, byte_in);
					if (bc_inc > 9'(sfd_pkg::MAX_PAYLOAD + 3)) begin
						phase_d          = sfd_pkg::PH_HUNT;
						byte_count_d     = 9'd0;
						res_vld          = 1'b1;
						res.frame_status = sfd_pkg::ST_BAD_LENGTH;
					end else if (byte_in == sfd_pkg::END_BYTE) begin
						if (use_crc) begin
							phase_d = sfd_pkg::PH_CRC_LO;
						end else begin
							phase_d          = sfd_pkg::PH_HUNT;
							byte_count_d     = 9'd0;
							res_vld          = 1'b1;
							res.frame_status = sfd_pkg::frame_verdict(bad_seen_q,
								held_valid_q, held_byte_q, bc_inc, 1'b0, 16'h0000, crc_q);
						end
					end else begin
						// payload leaves one byte late so the length byte stays behind
						res.frame_end     = 1'b0;
						res.payload_count = 8'd0;
						res.payload_byte  = held_byte_q;
						if (held_valid_q) begin
							if (held_byte_q == sfd_pkg::BAD_BYTE) begin
								bad_seen_d = 1'b1;
							end else if (!bad_seen_q
									&& emitted_q < 8'(sfd_pkg::MAX_PAYLOAD)) begin
								res_vld   = 1'b1;
								emitted_d = emitted_q + 8'd1;
							end
						end
						held_byte_d  = byte_in;
						held_valid_d = 1'b1;
					end
				end
				sfd_pkg::PH_CRC_LO: begin
					crc_low_d = byte_in;
					phase_d   = sfd_pkg::PH_CRC_HI;
				end
				sfd_pkg::PH_CRC_HI: begin
					phase_d          = sfd_pkg::PH_HUNT;
					byte_count_d     = 9'd0;
					res_vld          = 1'b1;
					res.frame_status = sfd_pkg::frame_verdict(bad_seen_q, held_valid_q,
						held_byte_q, byte_count_q, 1'b1, {byte_in, crc_low_q}, crc_q);
				end
				default: begin
					phase_d      = sfd_pkg::PH_HUNT;
					byte_count_d = 9'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sfd_pkg::PH_HUNT;
			byte_count_q <= 9'd0;
			held_byte_q  <= 8'd0;
			held_valid_q <= 1'b0;
			crc_q        <= 16'h0000;
			crc_low_q    <= 8'd0;
			bad_seen_q   <= 1'b0;
			emitted_q    <= 8'd0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			crc_q        <= crc_d;
			crc_low_q    <= crc_low_d;
			bad_seen_q   <= bad_seen_d;
			emitted_q    <= emitted_d;
		end
	end

endmodule

>>> src/serial_frame_deframer_crc16_unit.sv
`timescale 1ns / 1ps

// Delimited serial frame receiver with CRC-16/KERMIT check. Takes one received byte per
// cycle and gives at most one result per byte: a payload byte (frame_end 0) or a frame
// status (frame_end 1). A byte is registered on acceptance, run through the framing and
// CRC step, and its result lands in the output register. The sustained rate is one byte
// per cycle; a result held by the receiver stalls the step and then the input. Set use_crc
// (APB address 0, bit 0) only while idle.
module serial_frame_deframer_crc16_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  payload_byte,
	output logic        frame_end,
	output logic [2:0]  frame_status,
	output logic [7:0]  payload_count
);

	logic             use_crc_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             step_vld;
	sfd_pkg::result_t step_res;
	logic             out_valid_q;
	sfd_pkg::result_t out_q;

	assign pready = 1'b1;
	assign prdata = (paddr == sfd_pkg::ADDR_USE_CRC) ? {31'b0, use_crc_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_crc_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == sfd_pkg::ADDR_USE_CRC) begin
			use_crc_q <= pwdata[0];
		end
	end

	// the step runs when its result has somewhere to go
	assign advance    = valid_s1 && (!out_valid_q || result_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			byte_s1 <= rx_byte;
	end

	sfd_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.byte_in (byte_s1),
		.use_crc (use_crc_q),
		.res_vld (step_vld),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_vld;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_vld)
			out_q <= step_res;
	end

	assign result_valid  = out_valid_q;
	assign payload_byte  = out_q.payload_byte;
	assign frame_end     = out_q.frame_end;
	assign frame_status  = out_q.frame_status;
	assign payload_count = out_q.payload_count;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef enum {ROW_PREDICT, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [7:0]       val;
		bit               has;
		sfd_pkg::result_t res;
	} plan_row_t;

	typedef enum {
		K_GOOD, K_BADLEN, K_BADBYTE, K_BADCRC, K_ABORT, K_JUNK,
		K_OVERLONG, K_NOSTART, K_MAX
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  rx_byte = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [7:0]  payload_byte;
	logic        frame_end;
	logic [2:0]  frame_status;
	logic [7:0]  payload_count;

	// deframer state as the testbench sees it
	sfd_pkg::phase_t pr_phase;
	logic [8:0]  pr_cnt;
	logic [7:0]  pr_held;
	logic        pr_held_ok;
	logic [15:0] pr_crc;
	logic [7:0]  pr_crc_lo;
	logic        pr_bad;
	logic [7:0]  pr_sent;
	logic        cfg_use_crc;

	sfd_pkg::result_t rx_results_due[$];
	plan_row_t   plan[$];
	logic [7:0]  link_bytes[$];

	int mismatches = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;

	serial_frame_deframer_crc16_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.rx_byte       (rx_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.payload_byte  (payload_byte),
		.frame_end     (frame_end),
		.frame_status  (frame_status),
		.payload_count (payload_count)
	);

	always #5 clk = ~clk;

	// bitwise reflected crc, poly 0x8408
	function automatic logic [15:0] kermit_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
		return x;
	endfunction

	function automatic sfd_pkg::result_t status_res(input logic [2:0] s, input logic [7:0] n);
		sfd_pkg::result_t r;
		r = '0;
		r.frame_end = 1'b1;
		r.frame_status = s;
		r.payload_count = n;
		return r;
	endfunction

	function automatic sfd_pkg::result_t payload_res(input logic [7:0] b);
		sfd_pkg::result_t r;
		r = '0;
		r.payload_byte = b;
		return r;
	endfunction

	function automatic logic [2:0] frame_outcome(input bit chk, input logic [15:0] rx_crc);
		if (pr_bad)
			return sfd_pkg::ST_INVALID;
		if (pr_held_ok && pr_held == sfd_pkg::BAD_BYTE && pr_cnt <= sfd_pkg::MAX_PAYLOAD + 2)
			return sfd_pkg::ST_INVALID;
		if (!pr_held_ok || int'(pr_held) != int'(pr_cnt) - 2 || pr_held < 8'd4)
			return sfd_pkg::ST_BAD_LENGTH;
		if (chk && rx_crc != pr_crc)
			return sfd_pkg::ST_CRC;
		return sfd_pkg::ST_OK;
	endfunction

	task automatic deframe_byte(input logic [7:0] c, output bit has,
			output sfd_pkg::result_t r);
		has = 1'b0;
		r = '0;
		if (c == sfd_pkg::START_BYTE) begin
			if (pr_phase != sfd_pkg::PH_HUNT) begin
				has = 1'b1;
				r = status_res(sfd_pkg::ST_ABORTED, pr_sent);
			end
			pr_phase = sfd_pkg::PH_COLLECT;
			pr_cnt = 9'd1;
			pr_held = '0;
			pr_held_ok = 1'b0;
			pr_bad = 1'b0;
			pr_sent = '0;
			pr_crc = kermit_step(16'h0000, sfd_pkg::START_BYTE);
			pr_crc_lo = '0;
		end else begin
			case (pr_phase)
				sfd_pkg::PH_HUNT: begin
					pr_cnt = pr_cnt + 9'd1;
					if (pr_cnt > sfd_pkg::HUNT_LIMIT) begin
						pr_cnt = '0;
						has = 1'b1;
						r = status_res(sfd_pkg::ST_NO_START, 8'd0);
					end
				end
				sfd_pkg::PH_COLLECT: begin
					pr_cnt = pr_cnt + 9'd1;
					pr_crc = kermit_step(pr_crc, c);
					if (pr_cnt > sfd_pkg::MAX_PAYLOAD + 3) begin
						has = 1'b1;
						r = status_res(sfd_pkg::ST_BAD_LENGTH, pr_sent);
						pr_phase = sfd_pkg::PH_HUNT;
						pr_cnt = '0;
					end else if (c == sfd_pkg::END_BYTE) begin
						if (cfg_use_crc) begin
							pr_phase = sfd_pkg::PH_CRC_LO;
						end else begin
							has = 1'b1;
							r = status_res(frame_outcome(1'b0, 16'h0000), pr_sent);
							pr_phase = sfd_pkg::PH_HUNT;
							pr_cnt = '0;
						end
					end else begin
						if (pr_held_ok) begin
							if (pr_held == sfd_pkg::BAD_BYTE) begin
								pr_bad = 1'b1;
							end else if (!pr_bad && pr_sent < sfd_pkg::MAX_PAYLOAD) begin
								has = 1'b1;
								r = payload_res(pr_held);
								pr_sent = pr_sent + 8'd1;
							end
						end
						pr_held = c;
						pr_held_ok = 1'b1;
					end
				end
				sfd_pkg::PH_CRC_LO: begin
					pr_crc_lo = c;
					pr_phase = sfd_pkg::PH_CRC_HI;
				end
				default: begin
					has = 1'b1;
					r = status_res(frame_outcome(1'b1, {c, pr_crc_lo}), pr_sent);
					pr_phase = sfd_pkg::PH_HUNT;
					pr_cnt = '0;
				end
			endcase
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input bit t_has,
			input sfd_pkg::result_t t_res);
		bit has;
		sfd_pkg::result_t r;
		byte_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!byte_ready);
		deframe_byte(b, has, r);
		if (typed) begin
			has = t_has;
			r = t_res;
		end
		if (has)
			rx_results_due.push_back(r);
		// each further idle cycle follows with the same odds
		if ($urandom_range(99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		while (rx_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic v);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sfd_pkg::ADDR_USE_CRC;
		pwdata <= ($urandom() & 32'hFFFF_FFFE) | 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_use_crc = v;
	endtask

	function automatic void plan_row(input row_kind_t k, input logic [7:0] v, input bit has,
			input sfd_pkg::result_t r);
		plan_row_t p;
		p.kind = k;
		p.val = v;
		p.has = has;
		p.res = r;
		plan.push_back(p);
	endfunction

	function automatic logic [7:0] stray_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == sfd_pkg::START_BYTE)
			b = 8'h00;
		return b;
	endfunction

	function automatic logic [7:0] payload_pick();
		if ($urandom_range(99) < 95)
			return 8'($urandom_range(0, 252));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic build_frame(input frame_kind_t k);
		int n;
		int plen;
		int s;
		logic [7:0] lenb;
		logic [15:0] c;
		link_bytes.delete();
		if (k == K_NOSTART) begin
			n = $urandom_range(254, 300);
			repeat (n) link_bytes.push_back(stray_byte());
			return;
		end
		if (k == K_JUNK)
			repeat ($urandom_range(1, 8)) link_bytes.push_back(stray_byte());
		s = link_bytes.size();
		link_bytes.push_back(sfd_pkg::START_BYTE);
		if (k == K_ABORT) begin
			repeat ($urandom_range(0, 6)) link_bytes.push_back(payload_pick());
			return;
		end
		if (k == K_OVERLONG) begin
			repeat ($urandom_range(255, 258)) link_bytes.push_back(8'($urandom_range(0, 252)));
			link_bytes.push_back(sfd_pkg::END_BYTE);
			return;
		end
		if (k == K_MAX) begin
			plen = sfd_pkg::MAX_PAYLOAD;
		end else begin
			n = $urandom_range(99);
			plen = (n < 90) ? $urandom_range(3, 14)
				: (n < 98) ? $urandom_range(0, 40)
				: $urandom_range(41, sfd_pkg::MAX_PAYLOAD);
		end
		repeat (plen) link_bytes.push_back(payload_pick());
		lenb = 8'(plen + 1);
		if (k == K_BADLEN)
			lenb = $urandom_range(1) ? 8'(plen + 1 + $urandom_range(1, 3))
				: 8'($urandom_range(0, 5));
		if (k == K_BADBYTE) begin
			if (plen > 0 && $urandom_range(1))
				link_bytes[s + $urandom_range(1, plen)] = sfd_pkg::BAD_BYTE;
			else
				lenb = sfd_pkg::BAD_BYTE;
		end
		link_bytes.push_back(lenb);
		link_bytes.push_back(sfd_pkg::END_BYTE);
		if (cfg_use_crc) begin
			c = 16'h0000;
			for (int i = s; i < link_bytes.size(); i++)
				c = kermit_step(c, link_bytes[i]);
			if (k == K_BADCRC)
				c ^= 16'(1 << $urandom_range(0, 15));
			link_bytes.push_back(c[7:0]);
			link_bytes.push_back(c[15:8]);
		end
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items,
			input logic start_crc, input frame_kind_t lead, input bit pressure);
		int sent;
		int n;
		bit mid_done;
		bit press_done;
		frame_kind_t k;
		sent = 0;
		mid_done = 1'b0;
		press_done = 1'b0;
		write_cfg(start_crc);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		build_frame(lead);
		while (1) begin
			foreach (link_bytes[i])
				send_byte(link_bytes[i], 1'b0, 1'b0, '0);
			sent += link_bytes.size();
			if (sent >= n_items)
				break;
			if (!mid_done && sent >= n_items / 2) begin
				write_cfg(!cfg_use_crc);
				mid_done = 1'b1;
			end
			if (pressure && !press_done && sent >= 300) begin
				hold_reqs++;
				press_done = 1'b1;
			end
			n = $urandom_range(99);
			k = (n < 56) ? K_GOOD : (n < 64) ? K_BADLEN : (n < 71) ? K_BADBYTE
				: (n < 79) ? K_BADCRC : (n < 87) ? K_ABORT : (n < 97) ? K_JUNK
				: (n == 97) ? K_OVERLONG : (n == 98) ? K_NOSTART : K_MAX;
			build_frame(k);
		end
	endtask

	// receiver side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		sfd_pkg::result_t e;
		if (arst_n && result_valid && result_ready) begin
			if (rx_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result byte %0d end %0b status %0d count %0d",
					$time, payload_byte, frame_end, frame_status, payload_count);
			end else begin
				e = rx_results_due.pop_front();
				if (payload_byte !== e.payload_byte || frame_end !== e.frame_end
						|| frame_status !== e.frame_status
						|| payload_count !== e.payload_count) begin
					mismatches++;
					$display("%0t: expected %0d/%0b/%0d/%0d, got %0d/%0b/%0d/%0d",
						$time, e.payload_byte, e.frame_end, e.frame_status,
						e.payload_count, payload_byte, frame_end, frame_status,
						payload_count);
				end
			end
		end
	end

	// stall watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (result_valid && result_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, quiet, rx_results_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		pr_phase = sfd_pkg::PH_HUNT;
		pr_cnt = '0;
		pr_held = '0;
		pr_held_ok = 1'b0;
		pr_crc = '0;
		pr_crc_lo = '0;
		pr_bad = 1'b0;
		pr_sent = '0;
		cfg_use_crc = 1'b0;

		// good frame, payload 00 80 fc
		plan_row(ROW_TYPED, sfd_pkg::START_BYTE, 1'b0, '0);
		plan_row(ROW_TYPED, 8'h00, 1'b0, '0);
		plan_row(ROW_TYPED, 8'h80, 1'b1, payload_res(8'h00));
		plan_row(ROW_TYPED, 8'hFC, 1'b1, payload_res(8'h80));
		plan_row(ROW_TYPED, 8'h04, 1'b1, payload_res(8'hFC));
		plan_row(ROW_TYPED, sfd_pkg::END_BYTE, 1'b1, status_res(sfd_pkg::ST_OK, 8'd3));
		// length byte of 255
		plan_row(ROW_TYPED, sfd_pkg::START_BYTE, 1'b0, '0);
		plan_row(ROW_TYPED, sfd_pkg::BAD_BYTE, 1'b0, '0);
		plan_row(ROW_TYPED, sfd_pkg::END_BYTE, 1'b1, status_res(sfd_pkg::ST_INVALID, 8'd0));
		// 255 inside payload stops emission
		plan_row(ROW_TYPED, sfd_pkg::START_BYTE, 1'b0, '0);
		plan_row(ROW_TYPED, 8'h11, 1'b0, '0);
		plan_row(ROW_TYPED, sfd_pkg::BAD_BYTE, 1'b1, payload_res(8'h11));
		plan_row(ROW_TYPED, 8'h22, 1'b0, '0);
		plan_row(ROW_TYPED, sfd_pkg::END_BYTE, 1'b1, status_res(sfd_pkg::ST_INVALID, 8'd1));
		// restart aborts, then start-end with no length byte
		plan_row(ROW_TYPED, sfd_pkg::START_BYTE, 1'b0, '0);
		plan_row(ROW_TYPED, 8'h01, 1'b0, '0);
		plan_row(ROW_TYPED, sfd_pkg::START_BYTE, 1'b1, status_res(sfd_pkg::ST_ABORTED, 8'd0));
		plan_row(ROW_TYPED, sfd_pkg::END_BYTE, 1'b1,
			status_res(sfd_pkg::ST_BAD_LENGTH, 8'd0));
		// length below 4
		plan_row(ROW_TYPED, sfd_pkg::START_BYTE, 1'b0, '0);
		plan_row(ROW_TYPED, 8'h01, 1'b0, '0);
		plan_row(ROW_TYPED, 8'h02, 1'b1, payload_res(8'h01));
		plan_row(ROW_TYPED, sfd_pkg::END_BYTE, 1'b1,
			status_res(sfd_pkg::ST_BAD_LENGTH, 8'd1));
		// crc frame, mode switched off between end byte and crc bytes
		plan_row(ROW_CFG, 8'h01, 1'b0, '0);
		plan_row(ROW_PREDICT, sfd_pkg::START_BYTE, 1'b0, '0);
		plan_row(ROW_PREDICT, 8'h55, 1'b0, '0);
		plan_row(ROW_PREDICT, 8'hAA, 1'b0, '0);
		plan_row(ROW_PREDICT, 8'h33, 1'b0, '0);
		plan_row(ROW_PREDICT, 8'h04, 1'b0, '0);
		plan_row(ROW_PREDICT, sfd_pkg::END_BYTE, 1'b0, '0);
		plan_row(ROW_CFG, 8'h00, 1'b0, '0);
		begin
			logic [15:0] c;
			c = 16'h0000;
			for (int i = plan.size() - 7; i < plan.size() - 1; i++)
				c = kermit_step(c, plan[i].val);
			plan_row(ROW_PREDICT, c[7:0], 1'b0, '0);
			plan_row(ROW_PREDICT, c[15:8], 1'b0, '0);
		end

		tx_idle_pct = 31;
		rx_idle_pct = 48;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_cfg(plan[i].val[0]);
			else
				send_byte(plan[i].val, plan[i].kind == ROW_TYPED, plan[i].has, plan[i].res);
		end

		run_phase(31, 48, 450, 1'b0, K_NOSTART, 1'b0);
		run_phase(48, 31, 450, 1'b1, K_OVERLONG, 1'b0);
		run_phase(0, 0, 450, 1'b1, K_MAX, 1'b1);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
src/sfd_pkg.sv
src/sfd_frame.sv
src/serial_frame_deframer_crc16_unit.sv
tb/sv/tb.sv
